// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HQIS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define HQIS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/hqis_pkg.sv =====
// ----------------------------------------------------------------------------
// hqis_pkg
// Shared constants and types of the hybrid quick/insertion sorter.
// ----------------------------------------------------------------------------
package hqis_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_PLACE,
        ST_EM_RD,
        ST_EM_LD
    } hqis_state_t;

endpackage

// ===== rtl/hqis_store.sv =====
// ----------------------------------------------------------------------------
// hqis_store
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hqis_store
    import hqis_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0]        raddr,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/hqis_cmp.sv =====
// ----------------------------------------------------------------------------
// hqis_cmp
// Shared order comparator: true when a goes before b in the chosen order.
// ----------------------------------------------------------------------------
module hqis_cmp
    import hqis_pkg::*;
(
    input  logic                     descending,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output logic                     before_b
);

    always_comb
    begin
        if (descending)
        begin
            before_b = (a > b);
        end
        else
        begin
            before_b = (a < b);
        end
    end

endmodule

// ===== rtl/hybrid_quick_insertion_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// hybrid_quick_insertion_sorter_unit
// Collects a set of signed values, keeps it ordered as it arrives and emits
// it in ascending or descending order once the closing item is taken.
//
// channel  | valid         | stall         | payload
// ---------+---------------+---------------+---------------------------------
// item     | item_valid    | item_stall    | value, is_last
// result   | result_valid  | result_stall  | sorted_value, end_of_set,
//          |               |               | overflowed
// config   | cfg_write_en  | -             | cfg_write_data
//
// Each transaction is inserted in place, walking down from the top of the
// held elements, one compare per cycle through the single comparator and
// the store's one read port; into an empty store it is written directly.
// Emission reads each result through ST_EM_RD and ST_EM_LD.
// A full store drops the item in ST_IDLE. No clearing pass after reset.
// result_stall holds the output register; the sequencer waits behind it.
// ----------------------------------------------------------------------------
module hybrid_quick_insertion_sorter_unit
    import hqis_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_en,
    input  logic                     cfg_write_data,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     is_last,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     end_of_set,
    output logic                     overflowed
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hqis_state_t state_reg, state_next;

    logic                     desc_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     drop_reg, drop_next;
    logic                     last_reg, last_next;
    logic [ADDR_W-1:0]        j_reg, j_next;
    logic [ADDR_W-1:0]        k_reg, k_next;
    logic signed [DATA_W-1:0] key_reg, key_next;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_val_reg, out_val_next;
    logic                     out_end_reg, out_end_next;
    logic                     out_ovf_reg, out_ovf_next;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr;
    logic signed [DATA_W-1:0] mem_rdata;
    logic                     key_first;
    logic [CNT_W-1:0]         count_m1;
    logic                     out_free;

    hqis_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    hqis_cmp u_cmp (
        .descending (desc_reg),
        .a          (key_reg),
        .b          (mem_rdata),
        .before_b   (key_first)
    );

    assign count_m1 = count_reg - CNT_W'(1);
    assign out_free = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            desc_reg      <= 1'b0;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                desc_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg    <= last_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        key_reg     <= key_next;
        out_val_reg <= out_val_next;
        out_end_reg <= out_end_next;
        out_ovf_reg <= out_ovf_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        last_next      = last_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_val_next   = out_val_reg;
        out_end_next   = out_end_reg;
        out_ovf_next   = out_ovf_reg;
        mem_we         = 1'b0;
        mem_waddr      = j_reg + ADDR_W'(1);
        mem_wdata      = mem_rdata;
        mem_raddr      = j_reg;
        item_stall     = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                mem_raddr  = count_m1[ADDR_W-1:0];
                k_next     = '0;
                if (item_valid)
                begin
                    key_next  = value;
                    last_next = is_last;
                    j_next    = count_m1[ADDR_W-1:0];
                    if (count_reg == CNT_FULL)
                    begin
                        drop_next = 1'b1;
                        if (is_last)
                        begin
                            state_next = ST_EM_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = value;
                        count_next = CNT_W'(1);
                        if (is_last)
                        begin
                            state_next = ST_EM_RD;
                        end
                    end
                    else
                    begin
                        state_next = ST_INS_CMP;
                    end
                end
            end

            ST_INS_CMP:
            begin
                mem_we = 1'b1;
                if (key_first)
                begin
                    // shift the stored element up one place, fetch the next
                    if (j_reg == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        j_next    = j_reg - ADDR_W'(1);
                        mem_raddr = j_reg - ADDR_W'(1);
                    end
                end
                else
                begin
                    mem_wdata  = key_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = last_reg ? ST_EM_RD : ST_IDLE;
                end
            end

            ST_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = key_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = last_reg ? ST_EM_RD : ST_IDLE;
            end

            ST_EM_RD:
            begin
                mem_raddr  = k_reg;
                state_next = ST_EM_LD;
            end

            ST_EM_LD:
            begin
                mem_raddr = k_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = mem_rdata;
                    out_ovf_next   = drop_reg;
                    out_end_next   = (CNT_W'(k_reg) == count_m1);
                    if (CNT_W'(k_reg) == count_m1)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + ADDR_W'(1);
                        state_next = ST_EM_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign sorted_value = out_val_reg;
    assign end_of_set   = out_end_reg;
    assign overflowed   = out_ovf_reg;

endmodule

// ===== rtl/hqis_checker.sv =====
// ----------------------------------------------------------------------------
// hqis_checker
// Port-level checks on the sorter's handshakes and sequencing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hqis_checker
    import hqis_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     item_valid,
    input logic                     item_stall,
    input logic                     is_last,
    input logic                     result_valid,
    input logic                     result_stall,
    input logic signed [DATA_W-1:0] sorted_value,
    input logic                     end_of_set
);

    `HQIS_ASSERT_NXT(a_res_hold, result_valid && result_stall, result_valid)
    `HQIS_ASSERT_NXT(a_res_stable, result_valid && result_stall, $stable(sorted_value))
    // mid-set emission keeps the item side closed
    `HQIS_ASSERT_IMP(a_busy_emit, result_valid && !end_of_set, item_stall)
    // a closing transaction always starts work
    `HQIS_ASSERT_NXT(a_last_busy, item_valid && !item_stall && is_last, item_stall)

endmodule

bind hybrid_quick_insertion_sorter_unit hqis_checker u_hqis_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sorted_value (sorted_value),
    .end_of_set   (end_of_set)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sets of signed values into hybrid_quick_insertion_sorter_unit and
// checks every emitted element, in order, against a software sort of the
// same set. Covers both orders, the full and over-full store, equal values
// and a long hold-off on the result side that backs up the item channel.
// ----------------------------------------------------------------------------
module testbench;
    import hqis_pkg::*;

    localparam int SET_DEPTH    = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 470;
    localparam int SETTLE       = 100;
    localparam int LONG_HOLD    = 400;

    localparam logic ORDER_ASC  = 1'b0;
    localparam logic ORDER_DESC = 1'b1;

    typedef logic signed [DATA_W-1:0] elem_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        elem_t     value;
        logic      last;
        logic      typed;
        elem_t     exp_value;
    } dir_row_t;

    typedef struct packed {
        elem_t value;
        logic  end_of_set;
        logic  overflowed;
    } sorted_elem_t;

    localparam int DIR_ROWS = 21;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{ROW_ITEM, 32'sh7FFFFFFF, 1'b1, 1'b1, 32'sh7FFFFFFF},
        '{ROW_ITEM, 32'sh80000000, 1'b1, 1'b1, 32'sh80000000},
        '{ROW_ITEM, -32'sd1,       1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'sh80000000, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'sh7FFFFFFF, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'sd0,        1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'sd1,        1'b1, 1'b0, '0},
        '{ROW_ITEM, 32'sd5,        1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'sd5,        1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'sd5,        1'b1, 1'b0, '0},
        '{ROW_CFG,  32'sd1,        1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'shAAAAAAAA, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'sh55555555, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'sh80000000, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'sh7FFFFFFF, 1'b0, 1'b0, '0},
        '{ROW_ITEM, -32'sd1,       1'b1, 1'b0, '0},
        '{ROW_ITEM, 32'sd0,        1'b1, 1'b1, 32'sd0},
        '{ROW_CFG,  32'sd0,        1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'sd0,        1'b0, 1'b0, '0},
        '{ROW_ITEM, -32'sd5,       1'b1, 1'b0, '0},
        '{ROW_ITEM, -32'sd7,       1'b1, 1'b1, -32'sd7}
    };

    logic  clk;
    logic  rst_n;
    logic  cfg_write_en;
    logic  cfg_write_data;
    logic  item_valid;
    logic  item_stall;
    elem_t value;
    logic  is_last;
    logic  result_valid;
    logic  result_stall;
    elem_t sorted_value;
    logic  end_of_set;
    logic  overflowed;

    sorted_elem_t pending_sorted[$];
    elem_t        set_held[$];
    logic         set_dropped;
    logic         order_desc;
    int           fail_count;
    int           offered;
    logic         brisk;
    logic         hold_go;
    logic         hold_long;

    hybrid_quick_insertion_sorter_unit uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .value          (value),
        .is_last        (is_last),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .sorted_value   (sorted_value),
        .end_of_set     (end_of_set),
        .overflowed     (overflowed)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic elem_t rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh80000000 + elem_t'($urandom_range(0, 3));
            1: return 32'sh7FFFFFFF - elem_t'($urandom_range(0, 3));
            2: return elem_t'($urandom_range(0, 16)) - 32'sd8;
            default: return elem_t'($urandom);
        endcase
    endfunction

    // Collects the set; on the closing transaction sorts it and queues the results.
    task automatic sort_set_on_arrival(input elem_t v, input logic last);
        int    i;
        int    j;
        elem_t key;
        begin
            if (set_held.size() < SET_DEPTH)
                set_held.push_back(v);
            else
                set_dropped = 1'b1;
            if (last)
            begin
                for (i = 1; i < set_held.size(); i++)
                begin
                    key = set_held[i];
                    j = i;
                    while (j > 0 && (order_desc ? key > set_held[j-1] : key < set_held[j-1]))
                    begin
                        set_held[j] = set_held[j-1];
                        j--;
                    end
                    set_held[j] = key;
                end
                for (i = 0; i < set_held.size(); i++)
                    pending_sorted.push_back('{set_held[i], i == set_held.size() - 1,
                                               set_dropped});
                set_held.delete();
                set_dropped = 1'b0;
            end
        end
    endtask

    task automatic offer_value(input elem_t v, input logic last, input logic typed,
                               input elem_t typed_value);
        int gap;
        begin
            if (offered % 30 == 29)
                brisk = ($urandom_range(0, 2) == 0);
            offered++;
            gap = brisk ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            item_valid <= 1'b1;
            value      <= v;
            is_last    <= last;
            do
                @(posedge clk);
            while (item_stall);
            if (typed)
                pending_sorted.push_back('{typed_value, 1'b1, 1'b0});
            else
                sort_set_on_arrival(v, last);
        end
    endtask

    // Order changes only with the block drained and settled.
    task automatic set_order(input logic desc);
        begin
            item_valid <= 1'b0;
            while (pending_sorted.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
            cfg_write_en   <= 1'b1;
            cfg_write_data <= desc;
            @(posedge clk);
            cfg_write_en   <= 1'b0;
            order_desc = desc;
        end
    endtask

    initial
    begin : item_side
        int n;
        int k;
        int r;
        int set_no;
        int sent;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 1'b0;
        item_valid     = 1'b0;
        value          = '0;
        is_last        = 1'b0;
        set_dropped    = 1'b0;
        order_desc     = ORDER_ASC;
        fail_count     = 0;
        offered        = 0;
        brisk          = 1'b0;
        hold_go        = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIR_ROWS; n++)
        begin
            if (DIR_TAB[n].kind == ROW_CFG)
                set_order(DIR_TAB[n].value[0]);
            else
                offer_value(DIR_TAB[n].value, DIR_TAB[n].last, DIR_TAB[n].typed,
                            DIR_TAB[n].exp_value);
        end

        hold_go = 1'b1;
        brisk   = 1'b1;
        set_no  = 0;
        sent    = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (set_no < 6)
                n = $urandom_range(1, 4);
            else if (set_no == 6)
                n = SET_DEPTH;
            else if (set_no == 7)
                n = SET_DEPTH + 1;
            else
            begin
                r = $urandom_range(0, 19);
                if (r < 14)
                    n = $urandom_range(1, 16);
                else if (r < 18)
                    n = $urandom_range(17, SET_DEPTH);
                else
                    n = $urandom_range(SET_DEPTH + 1, SET_DEPTH + 8);
            end
            for (k = 0; k < n; k++)
                offer_value(rand_value(), k == n - 1, 1'b0, '0);
            sent += n;
            set_no++;
            if ($urandom_range(0, 3) == 0)
                set_order(($urandom_range(0, 1) == 1) ? ORDER_DESC : ORDER_ASC);
        end

        item_valid <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("[hybrid_quick_insertion_sorter_unit] OK");
        else
            $display("[hybrid_quick_insertion_sorter_unit] ERROR");
        $finish;
    end

    initial
    begin : long_hold
        hold_long = 1'b0;
        wait (hold_go == 1'b1);
        @(posedge clk);
        hold_long <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long <= 1'b0;
    end

    initial
    begin : result_side
        int           wait_left;
        int           taken;
        logic         quiet;
        sorted_elem_t e;
        wait_left    = 0;
        taken        = 0;
        quiet        = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (pending_sorted.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none actual %0d",
                             $time, sorted_value);
                    fail_count++;
                end
                else
                begin
                    e = pending_sorted.pop_front();
                    if (sorted_value !== e.value)
                    begin
                        $display("%0t: sorted_value expected %0d actual %0d",
                                 $time, e.value, sorted_value);
                        fail_count++;
                    end
                    if (end_of_set !== e.end_of_set)
                    begin
                        $display("%0t: end_of_set expected %0b actual %0b",
                                 $time, e.end_of_set, end_of_set);
                        fail_count++;
                    end
                    if (overflowed !== e.overflowed)
                    begin
                        $display("%0t: overflowed expected %0b actual %0b",
                                 $time, e.overflowed, overflowed);
                        fail_count++;
                    end
                end
                taken++;
                if (taken % 50 == 0)
                    quiet = ($urandom_range(0, 2) == 0);
                wait_left = quiet ? 0 : $urandom_range(0, 15);
            end
            else if (wait_left > 0)
                wait_left--;
            result_stall <= hold_long || (wait_left > 0);
        end
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("[hybrid_quick_insertion_sorter_unit] ERROR");
        $finish;
    end

endmodule
